### rtl/core/pss_pkg.sv
// pss_pkg: shared types and constants for the priority schedule simulator core
// depends on nothing; imported by pss_ctrl, pss_datapath and the top level
`default_nettype none

package pss_pkg;

  // fixed widths of the result fields
  localparam int PRIO_W    = 8;
  localparam int WAIT_W    = 13;
  localparam int PROC_ID_W = 2;
  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store one descriptor in the next slot
    logic scan_clr;   // restart the selection scan at slot 0
    logic scan_step;  // examine one slot in the selection scan
    logic tick_step;  // advance the simulation by one tick
    logic emit_step;  // load one result into the output register
    logic batch_clr;  // end of batch, return counters to zero
  } pss_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;       // the slot being loaded is the final one
    logic any_left;   // some loaded process still has burst left
    logic run_valid;  // a process currently owns the cpu
    logic scan_last;  // scan index sits on the last loaded slot
    logic emit_last;  // emit index sits on the last loaded slot
  } pss_sts_t;

endpackage

`default_nettype wire

### rtl/core/pss_ctrl.sv
// pss_ctrl: sequencing state machine for load, selection scan, tick and result phases
// depends on pss_pkg; drives the command struct into pss_datapath
`default_nettype none

module pss_ctrl import pss_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     last_proc,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire pss_sts_t sts,
  output pss_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_SCAN,
    S_TICK,
    S_EMIT
  } state_t;

  state_t state;
  logic   emit_free;

  // descriptors are taken only while loading
  assign in_stall  = (state != S_LOAD);
  assign emit_free = !out_valid || !out_stall;

  // command decode
  always_comb begin
    cmd = '0;
    case (state)
      S_LOAD: begin
        cmd.load = in_valid;
      end
      S_CHECK: begin
        cmd.scan_clr = sts.any_left && !sts.run_valid;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
      end
      S_EMIT: begin
        cmd.emit_step = emit_free;
        cmd.batch_clr = emit_free && sts.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_valid && (last_proc || sts.full)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!sts.any_left) begin
            state <= S_EMIT;
          end else if (sts.run_valid) begin
            state <= S_TICK;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state <= S_TICK;
          end
        end
        S_TICK: begin
          state <= S_CHECK;
        end
        S_EMIT: begin
          if (emit_free && sts.emit_last) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // a tick only runs while some burst is left
  a_tick_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_step |-> sts.any_left)
    else $error("tick issued with no burst left");

  // load, scan and tick commands and emit_step are mutually exclusive; batch_clr only comes with emit_step
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan_clr, cmd.scan_step, cmd.tick_step, cmd.emit_step}))
    else $error("more than one datapath command at once");

  // a descriptor that does not end the batch keeps the input open
  a_keep_loading: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !last_proc && !sts.full) |=> !in_stall)
    else $error("input closed before the batch ended");

  // the end of a selection scan is always followed by a tick
  a_scan_then_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && sts.scan_last) |=> cmd.tick_step)
    else $error("selection scan not followed by a tick");

endmodule

`default_nettype wire

### rtl/core/pss_datapath.sv
// pss_datapath: descriptor stores, per-slot tick lanes, selection scan and result register
// depends on pss_pkg; controlled by pss_ctrl through the command and status structs
`default_nettype none

module pss_datapath import pss_pkg::*; #(
  parameter int NUM_PROCS = 4,
  parameter int TIME_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [TIME_BITS-1:0] burst,
  input  wire logic [TIME_BITS-1:0] arrival,
  input  wire logic [PRIO_W-1:0]    prio,
  input  wire pss_cmd_t             cmd,
  output pss_sts_t                  sts,
  output logic [PROC_ID_W-1:0]      proc_id,
  output logic [WAIT_W-1:0]         wait_ticks,
  output logic [WAIT_W-1:0]         turnaround,
  output logic                      last_result
);

  localparam int IDX_W  = $clog2(NUM_PROCS);
  localparam int CNT_W  = $clog2(NUM_PROCS + 1);
  localparam int TICK_W = TIME_BITS + 1;
  localparam int SUM_W  = ((WAIT_W > TIME_BITS) ? WAIT_W : TIME_BITS) + 1;

  // per-slot stores
  logic [TIME_BITS-1:0] burst_store   [NUM_PROCS];
  logic [TIME_BITS-1:0] remaining     [NUM_PROCS];
  logic [TIME_BITS-1:0] arrival_store [NUM_PROCS];
  logic [PRIO_W-1:0]    prio_store    [NUM_PROCS];
  logic [WAIT_W-1:0]    wait_count    [NUM_PROCS];

  // control registers
  logic [CNT_W-1:0]  load_count;
  logic [IDX_W-1:0]  running_proc;
  logic              running_valid;
  logic [TICK_W-1:0] tick_now;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  best_idx;
  logic [PRIO_W-1:0] best_prio;
  logic              found;
  logic [IDX_W-1:0]  emit_idx;

  // combinational helpers
  logic [NUM_PROCS-1:0] alive;
  logic [NUM_PROCS-1:0] arrived;
  logic [NUM_PROCS-1:0] waiting;
  logic [IDX_W-1:0]     load_slot;
  logic [CNT_W-1:0]     n_minus1;
  logic [IDX_W-1:0]     last_idx;
  logic                 scan_take;
  logic                 found_next;
  logic [IDX_W-1:0]     best_idx_next;
  logic                 run_ends;
  logic [SUM_W-1:0]     ta_sum;
  logic [WAIT_W-1:0]    ta_sat;

  // per-slot lane flags
  always_comb begin
    for (int i = 0; i < NUM_PROCS; i++) begin
      alive[i]   = (CNT_W'(i) < load_count) && (remaining[i] != '0);
      arrived[i] = ({1'b0, arrival_store[i]} <= tick_now);
      waiting[i] = alive[i] && arrived[i] && (IDX_W'(i) != running_proc)
                   && (wait_count[i] != WAIT_MAX);
    end
  end

  // slot selection and batch bounds
  assign load_slot = (load_count >= CNT_W'(NUM_PROCS)) ? IDX_W'(NUM_PROCS - 1)
                                                       : load_count[IDX_W-1:0];
  assign n_minus1  = load_count - CNT_W'(1);
  assign last_idx  = n_minus1[IDX_W-1:0];

  // one slot per cycle of the selection scan
  assign scan_take     = alive[scan_idx] && arrived[scan_idx]
                         && (!found || (prio_store[scan_idx] < best_prio));
  assign found_next    = found || scan_take;
  assign best_idx_next = scan_take ? scan_idx : best_idx;
  assign run_ends      = (remaining[running_proc] == TIME_BITS'(1));

  // saturated turnaround of the slot being emitted
  assign ta_sum = SUM_W'(wait_count[emit_idx]) + SUM_W'(burst_store[emit_idx]);
  assign ta_sat = (ta_sum > SUM_W'(WAIT_MAX)) ? WAIT_MAX : ta_sum[WAIT_W-1:0];

  // status to the controller
  always_comb begin
    sts.full      = (load_slot == IDX_W'(NUM_PROCS - 1));
    sts.any_left  = |alive;
    sts.run_valid = running_valid;
    sts.scan_last = (scan_idx == last_idx);
    sts.emit_last = (emit_idx == last_idx);
  end

  // descriptor stores
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      burst_store[load_slot]   <= burst;
      arrival_store[load_slot] <= arrival;
      prio_store[load_slot]    <= prio;
    end
  end

  // remaining burst, loaded then counted down by the running process
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remaining[load_slot] <= burst;
    end else if (cmd.tick_step && running_valid) begin
      remaining[running_proc] <= remaining[running_proc] - TIME_BITS'(1);
    end
  end

  // wait counters, one lane per slot
  always_ff @(posedge clk) begin
    if (rst || cmd.batch_clr) begin
      for (int i = 0; i < NUM_PROCS; i++) begin
        wait_count[i] <= '0;
      end
    end else if (cmd.load) begin
      wait_count[load_slot] <= '0;
    end else if (cmd.tick_step && running_valid) begin
      for (int i = 0; i < NUM_PROCS; i++) begin
        if (waiting[i]) begin
          wait_count[i] <= wait_count[i] + WAIT_W'(1);
        end
      end
    end
  end

  // load count, tick counter and running process
  always_ff @(posedge clk) begin
    if (rst || cmd.batch_clr) begin
      load_count    <= '0;
      tick_now      <= '0;
      running_proc  <= '0;
      running_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        load_count <= CNT_W'(load_slot) + CNT_W'(1);
      end
      if (cmd.scan_step && sts.scan_last) begin
        running_valid <= found_next;
        running_proc  <= best_idx_next;
      end else if (cmd.tick_step && running_valid && run_ends) begin
        running_valid <= 1'b0;
      end
      // tick saturates once it is past every possible arrival
      if (cmd.tick_step && !tick_now[TICK_W-1]) begin
        tick_now <= tick_now + TICK_W'(1);
      end
    end
  end

  // selection scan registers
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clr) begin
      scan_idx  <= '0;
      found     <= 1'b0;
      best_idx  <= '0;
      best_prio <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
      found    <= found_next;
      best_idx <= best_idx_next;
      if (scan_take) begin
        best_prio <= prio_store[scan_idx];
      end
    end
  end

  // emit index
  always_ff @(posedge clk) begin
    if (rst || cmd.batch_clr) begin
      emit_idx <= '0;
    end else if (cmd.emit_step) begin
      emit_idx <= emit_idx + IDX_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      proc_id     <= PROC_ID_W'(emit_idx);
      wait_ticks  <= wait_count[emit_idx];
      turnaround  <= ta_sat;
      last_result <= sts.emit_last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/priority_schedule_simulator_core.sv
// priority schedule simulator: one descriptor beat per cycle while loading.
// after the last descriptor (or a full store) each tick runs the check and tick states, and a
// tick that finds the cpu free adds a selection scan over the loaded slots between them.
// n result beats then follow, one per cycle when not stalled; loading reopens after the last.
// synchronous reset clears the state machine, counters and wait counters; stores are not reset.
`default_nettype none

module priority_schedule_simulator_core import pss_pkg::*; #(
  parameter int NUM_PROCS = 4,
  parameter int TIME_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [TIME_BITS-1:0] burst,
  input  wire logic [TIME_BITS-1:0] arrival,
  input  wire logic [PRIO_W-1:0]    prio,
  input  wire logic                 last_proc,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PROC_ID_W-1:0]      proc_id,
  output logic [WAIT_W-1:0]         wait_ticks,
  output logic [WAIT_W-1:0]         turnaround,
  output logic                      last_result
);

  pss_cmd_t cmd;
  pss_sts_t sts;

  // sequencing
  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_proc (last_proc),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores, lanes and result register
  pss_datapath #(
    .NUM_PROCS (NUM_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .arrival     (arrival),
    .prio        (prio),
    .cmd         (cmd),
    .sts         (sts),
    .proc_id     (proc_id),
    .wait_ticks  (wait_ticks),
    .turnaround  (turnaround),
    .last_result (last_result)
  );

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for priority_schedule_simulator_core
// loads process batches and checks the per-process wait and turnaround beats against
// a scheduling predictor kept in a small class; depends on pss_pkg and the core rtl only

module tb;
  import pss_pkg::*;

  localparam int NUM_PROCS    = 4;
  localparam int TIME_BITS    = 10;
  localparam int ITEM_COUNT   = 160;
  localparam int CALM_ITEMS   = 30;
  localparam int STALL_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 64;

  // predicts the result beats of each batch and holds them until they arrive
  class sched_board;
    typedef struct {
      logic [pss_pkg::PROC_ID_W-1:0] proc;
      logic [pss_pkg::WAIT_W-1:0]    waited;
      logic [pss_pkg::WAIT_W-1:0]    turnaround;
      logic                          last_flag;
    } proc_stat_t;

    proc_stat_t                 due_stats[$];
    logic [TIME_BITS-1:0]       burst_tab[NUM_PROCS];
    logic [TIME_BITS-1:0]       arrival_tab[NUM_PROCS];
    logic [pss_pkg::PRIO_W-1:0] prio_tab[NUM_PROCS];
    int                         loaded;
    int                         errors;

    function new();
      loaded = 0;
      errors = 0;
    endfunction

    function int pending();
      return due_stats.size();
    endfunction

    // store one descriptor beat; when the batch closes, run the schedule tick by tick
    function void note_descriptor(logic [TIME_BITS-1:0] b, logic [TIME_BITS-1:0] a,
                                  logic [pss_pkg::PRIO_W-1:0] p, logic last);
      int                   slot;
      int                   tick;
      int                   owner;
      int                   work;
      int                   ta;
      bit                   busy;
      logic [TIME_BITS-1:0] left[NUM_PROCS];
      int                   waited[NUM_PROCS];
      proc_stat_t           stat;
      slot = (loaded >= NUM_PROCS) ? NUM_PROCS - 1 : loaded;
      burst_tab[slot]   = b;
      arrival_tab[slot] = a;
      prio_tab[slot]    = p;
      loaded = slot + 1;
      if (!last && loaded < NUM_PROCS) return;

      work = 0;
      for (int i = 0; i < loaded; i++) begin
        left[i]   = burst_tab[i];
        waited[i] = 0;
        work += int'(burst_tab[i]);
      end
      busy  = 0;
      owner = 0;
      tick  = 0;
      while (work > 0) begin
        // cpu free: lowest prio among arrived, unfinished; ties keep the lower index
        if (!busy) begin
          for (int i = 0; i < loaded; i++) begin
            if (left[i] != 0 && int'(arrival_tab[i]) <= tick &&
                (!busy || prio_tab[i] < prio_tab[owner])) begin
              owner = i;
              busy  = 1;
            end
          end
        end
        // idle tick when nothing has arrived
        if (busy) begin
          left[owner]--;
          work--;
          for (int i = 0; i < loaded; i++) begin
            if (i != owner && int'(arrival_tab[i]) <= tick && left[i] != 0 &&
                waited[i] < int'(pss_pkg::WAIT_MAX))
              waited[i]++;
          end
          if (left[owner] == 0) busy = 0;
        end
        tick++;
      end

      // one result per loaded slot, index order, saturated turnaround
      for (int i = 0; i < loaded; i++) begin
        ta = waited[i] + int'(burst_tab[i]);
        if (ta > int'(pss_pkg::WAIT_MAX)) ta = int'(pss_pkg::WAIT_MAX);
        stat.proc       = pss_pkg::PROC_ID_W'(i);
        stat.waited     = pss_pkg::WAIT_W'(waited[i]);
        stat.turnaround = pss_pkg::WAIT_W'(ta);
        stat.last_flag  = (i == loaded - 1);
        due_stats.push_back(stat);
      end
      loaded = 0;
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(logic [pss_pkg::PROC_ID_W-1:0] id,
                               logic [pss_pkg::WAIT_W-1:0] w,
                               logic [pss_pkg::WAIT_W-1:0] ta, logic last);
      proc_stat_t want;
      if (due_stats.size() == 0) begin
        $display("%0t: result beat proc_id %0d with nothing expected", $time, id);
        errors++;
        return;
      end
      want = due_stats.pop_front();
      if (id !== want.proc) begin
        $display("%0t: proc_id expected %0d actual %0d", $time, want.proc, id);
        errors++;
      end
      if (w !== want.waited) begin
        $display("%0t: wait_ticks expected %0d actual %0d", $time, want.waited, w);
        errors++;
      end
      if (ta !== want.turnaround) begin
        $display("%0t: turnaround expected %0d actual %0d", $time, want.turnaround, ta);
        errors++;
      end
      if (last !== want.last_flag) begin
        $display("%0t: last_result expected %0d actual %0d", $time, want.last_flag, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [TIME_BITS-1:0]   burst = '0;
  logic [TIME_BITS-1:0]   arrival = '0;
  logic [PRIO_W-1:0]      prio = '0;
  logic                   last_proc = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PROC_ID_W-1:0]   proc_id;
  logic [WAIT_W-1:0]      wait_ticks;
  logic [WAIT_W-1:0]      turnaround;
  logic                   last_result;

  sched_board board = new();

  int          items_sent = 0;
  bit          in_noisy = 1'b1;
  bit          out_noisy = 1'b1;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  priority_schedule_simulator_core #(
    .NUM_PROCS (NUM_PROCS),
    .TIME_BITS (TIME_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .burst       (burst),
    .arrival     (arrival),
    .prio        (prio),
    .last_proc   (last_proc),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .proc_id     (proc_id),
    .wait_ticks  (wait_ticks),
    .turnaround  (turnaround),
    .last_result (last_result)
  );

  always #4 clk = ~clk;

  // result side: check accepted beats, then pick the next stall state
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(proc_id, wait_ticks, turnaround, last_result);
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && out_noisy && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drive one descriptor beat and hold it until accepted, then maybe pause
  task send_descriptor(input logic [TIME_BITS-1:0] b, input logic [TIME_BITS-1:0] a,
                       input logic [PRIO_W-1:0] p, input logic l);
    in_valid  <= 1'b1;
    burst     <= b;
    arrival   <= a;
    prio      <= p;
    last_proc <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_descriptor(b, a, p, l);
    items_sent++;
    if (in_noisy && !calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // one batch of 1 to 4 descriptors, mostly short bursts and early arrivals
  task send_random_batch();
    int                   n;
    logic [TIME_BITS-1:0] b;
    logic [TIME_BITS-1:0] a;
    logic [PRIO_W-1:0]    p;
    logic                 l;
    n = $urandom_range(1, NUM_PROCS);
    in_noisy  = ($urandom_range(0, 3) != 0);
    out_noisy = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 11))
        0:       b = TIME_BITS'($urandom);
        1:       b = '0;
        default: b = TIME_BITS'($urandom_range(1, 15));
      endcase
      a = ($urandom_range(0, 11) == 0) ? TIME_BITS'($urandom)
                                         : TIME_BITS'($urandom_range(0, 31));
      // narrow prio range half the time so ties come up often
      p = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
      // a stray last flag now and then cuts the batch short
      if (k < n - 1) l = ($urandom_range(0, 15) == 0);
      else if (n < NUM_PROCS) l = 1'b1;
      else l = 1'($urandom_range(0, 1));
      send_descriptor(b, a, p, l);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // lone process arriving late: long idle stretch, extreme fields
    send_descriptor(10'd1023, 10'd1023, 8'd255, 1'b1);
    // zero burst alone
    send_descriptor(10'd0, 10'd0, 8'd0, 1'b1);
    // store full without last flag, all prios tied
    send_descriptor(10'd3, 10'd0, 8'd7, 1'b0);
    send_descriptor(10'd2, 10'd0, 8'd7, 1'b0);
    send_descriptor(10'd5, 10'd0, 8'd7, 1'b0);
    send_descriptor(10'd1, 10'd0, 8'd7, 1'b0);
    // gap between first finish and next arrival
    send_descriptor(10'd2, 10'd0, 8'd9, 1'b0);
    send_descriptor(10'd3, 10'd10, 8'd4, 1'b1);
    // staggered arrivals, better prio arriving while another runs
    send_descriptor(10'd4, 10'd0, 8'd200, 1'b0);
    send_descriptor(10'd2, 10'd1, 8'd10, 1'b0);
    send_descriptor(10'd3, 10'd2, 8'd5, 1'b0);
    send_descriptor(10'd1, 10'd3, 8'd0, 1'b1);
    // maximum bursts for the largest waits
    send_descriptor(10'd1023, 10'd0, 8'd3, 1'b0);
    send_descriptor(10'd1023, 10'd0, 8'd2, 1'b0);
    send_descriptor(10'd1023, 10'd0, 8'd1, 1'b0);
    send_descriptor(10'd1023, 10'd0, 8'd0, 1'b1);
    // zero burst next to a real one
    send_descriptor(10'd0, 10'd5, 8'd1, 1'b0);
    send_descriptor(10'd6, 10'd0, 8'd2, 1'b1);
    // every burst zero, run ends at once
    send_descriptor(10'd0, 10'd0, 8'd0, 1'b0);
    send_descriptor(10'd0, 10'd0, 8'd0, 1'b1);
    // alternating bit patterns
    send_descriptor(10'd1, 10'h2aa, 8'h55, 1'b0);
    send_descriptor(10'd1, 10'h155, 8'haa, 1'b1);

    while (items_sent < ITEM_COUNT) begin
      if (items_sent >= ITEM_COUNT - CALM_ITEMS) calm = 1'b1;
      send_random_batch();
    end
    // close a batch left open by a stray last flag
    if (board.loaded != 0) send_descriptor(10'd1, 10'd0, 8'd0, 1'b1);
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
